// ===== src/form_query_string_decoder_macros.svh =====
// Assertion helpers for the query string decoder checks
`ifndef FORM_QUERY_STRING_DECODER_MACROS_SVH
`define FORM_QUERY_STRING_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define FQSD_ASSERT_NOW(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("fqsd check failed");

// next-cycle implication, off during reset
`define FQSD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("fqsd check failed");

// next-cycle implication that also holds across reset
`define FQSD_ASSERT_ALWAYS(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("fqsd check failed");

`endif

// ===== src/fqsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fqsd_pkg;

  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX1 = 2'd2
  } esc_t;

  // flags: bit0 key bad escape, bit1 key bad path,
  //        bit2 value bad escape, bit3 value bad path
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [3:0]  flags;
  } res_t;

  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     slot;
  } batch_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = (c >= 8'h41) ? ((c & CASE_MASK) - 8'h37) : (c - 8'h30);
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/fqsd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fqsd_core import fqsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  output batch_t          batch
);

  logic       open_r, open_nxt;
  logic       val_r, val_nxt;
  esc_t       ph_r, ph_nxt;
  logic [7:0] held_r, held_nxt;
  logic       cut_r, cut_nxt;
  logic [3:0] flags_r, flags_nxt;

  res_t [2:0] slot;
  logic [1:0] n;
  kind_t      dkind;
  logic [7:0] bx;
  logic [7:0] dec;
  logic [3:0] f_esc;
  logic [3:0] f_path;

  always_comb begin
    open_nxt  = open_r;
    val_nxt   = val_r;
    ph_nxt    = ph_r;
    held_nxt  = held_r;
    cut_nxt   = cut_r;
    flags_nxt = flags_r;
    slot      = '0;
    n         = 2'd0;
    dkind     = val_r ? KIND_VALUE : KIND_KEY;
    bx        = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    dec       = {hex_val(held_r), hex_val(bx)};
    f_esc     = val_r ? 4'b0100 : 4'b0001;
    f_path    = val_r ? 4'b1000 : 4'b0010;

    if (in_end || in_byte == CH_AMP || (in_byte == CH_EQ && !val_r)) begin
      // pending escape at a field boundary is malformed
      if (ph_r == ESC_PCT || ph_r == ESC_HEX1) begin
        flags_nxt = flags_nxt | f_esc;
        if (!cut_r) begin
          slot[n] = '{kind: dkind, data: CH_PCT, flags: 4'd0};
          n = n + 2'd1;
        end
      end
      if (ph_r == ESC_HEX1 && !cut_r) begin
        slot[n] = '{kind: dkind, data: held_r, flags: 4'd0};
        n = n + 2'd1;
      end
      ph_nxt = ESC_NONE;
      if (in_end || in_byte == CH_AMP) begin
        if (open_r) begin
          slot[n] = '{kind: KIND_END, data: 8'd0, flags: flags_nxt};
          n = n + 2'd1;
        end
        open_nxt  = 1'b0;
        val_nxt   = 1'b0;
        cut_nxt   = 1'b0;
        flags_nxt = 4'd0;
      end else begin
        open_nxt = 1'b1;
        val_nxt  = 1'b1;
        cut_nxt  = 1'b0;
      end
    end else begin
      open_nxt = 1'b1;
      if (ph_r == ESC_HEX1 && is_hex(bx)) begin
        ph_nxt = ESC_NONE;
        if (dec == CH_SLASH || dec == 8'd0) flags_nxt = flags_nxt | f_path;
        if (dec == 8'd0) begin
          cut_nxt = 1'b1;
        end else if (!cut_r) begin
          slot[n] = '{kind: dkind, data: dec, flags: 4'd0};
          n = n + 2'd1;
        end
      end else if (ph_r == ESC_PCT && is_hex(bx)) begin
        held_nxt = bx;
        ph_nxt   = ESC_HEX1;
      end else begin
        if (ph_r == ESC_PCT || ph_r == ESC_HEX1) begin
          flags_nxt = flags_nxt | f_esc;
          if (!cut_r) begin
            slot[n] = '{kind: dkind, data: CH_PCT, flags: 4'd0};
            n = n + 2'd1;
          end
        end
        if (ph_r == ESC_HEX1 && !cut_r) begin
          slot[n] = '{kind: dkind, data: held_r, flags: 4'd0};
          n = n + 2'd1;
        end
        if (bx == CH_PCT) begin
          ph_nxt = ESC_PCT;
        end else begin
          ph_nxt = ESC_NONE;
          if (!cut_r) begin
            slot[n] = '{kind: dkind, data: bx, flags: 4'd0};
            n = n + 2'd1;
          end
        end
      end
    end

    batch.cnt  = n;
    batch.slot = slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      val_r   <= 1'b0;
      ph_r    <= ESC_NONE;
      cut_r   <= 1'b0;
      flags_r <= 4'd0;
    end else if (step_en) begin
      open_r  <= open_nxt;
      val_r   <= val_nxt;
      ph_r    <= ph_nxt;
      cut_r   <= cut_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 8'd0;
    end else if (step_en) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/fqsd_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fqsd_out import fqsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire batch_t      batch,
  output logic             load_ok,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  res_t [2:0] slot_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  res_t       cur;
  logic       fire;
  logic       done;

  assign cur        = slot_r[idx_r];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = (idx_r == cnt_r - 2'd1);
  assign out_tuser  = cur.kind;
  assign out_tdata  = {4'd0, cur.flags, cur.data};
  assign fire       = out_tvalid && out_tready;
  assign done       = fire && out_tlast;
  assign load_ok    = !out_tvalid || done;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = batch.cnt;
      idx_nxt = 2'd0;
    end else if (done) begin
      cnt_nxt = 2'd0;
      idx_nxt = 2'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= batch.slot;
    end
  end

endmodule

`default_nettype wire

// ===== src/form_query_string_decoder.sv =====
// Path: an accepted word reaches the output through one input register and one
//   result register; a word yields up to 3 results.
// Throughput: one input word per cycle while out_tready is high and each word
//   yields one result or none; more hold the buffer until the last is taken.
// Reset: rst_n low (synchronous) empties both registers and clears decoder state.
`timescale 1ns / 1ps
`default_nettype none

module form_query_string_decoder import fqsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic        in_tlast,   // is_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] data_byte, [8] key_bad_escape,
                                       // [9] key_bad_path, [10] value_bad_escape,
                                       // [11] value_bad_path, [15:12] zero
  output logic [1:0]       out_tuser,  // [1:0] item_kind
  output logic             out_tlast   // run_last
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       load_ok;
  logic       consume;
  batch_t     batch;

  assign consume   = in_valid_r && load_ok;
  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  fqsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (consume),
    .in_byte (in_byte_r),
    .in_end  (in_end_r),
    .batch   (batch)
  );

  fqsd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume),
    .batch      (batch),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== src/fqsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "form_query_string_decoder_macros.svh"

module fqsd_checker import fqsd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  `FQSD_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n, !out_tvalid)
  `FQSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `FQSD_ASSERT_NOW(a_end_is_last, clk, rst_n, out_tvalid && out_tuser == KIND_END,
    out_tlast && out_tdata[7:0] == 8'd0)
  `FQSD_ASSERT_NOW(a_data_no_flags, clk, rst_n, out_tvalid && out_tuser != KIND_END,
    out_tdata[15:8] == 8'd0 && (out_tuser == KIND_KEY || out_tuser == KIND_VALUE))

endmodule

bind form_query_string_decoder fqsd_checker u_chk (.*);

`default_nettype wire
